// File: rtl/fwcrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwcrc_pkg
// Shared types, constants and the byte-wise CRC-32 update for the firmware
// image validator.
// ----------------------------------------------------------------------------
package fwcrc_pkg;

  // Width of image sizes and of the byte counter
  localparam int unsigned SizeBits = 24;

  // Reflected CRC-32 constants
  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcOnes = 32'hFFFF_FFFF;

  // APB address width and register indexes
  localparam int unsigned AddrBits = 5;

  typedef enum logic [2:0] {
    RegRequiredFlag  = 3'd0,
    RegRequiredStart = 3'd1,
    RegSizeLimit     = 3'd2,
    RegRecordFlag    = 3'd3,
    RegRecordStart   = 3'd4,
    RegRecordSize    = 3'd5,
    RegRecordCrc     = 3'd6
  } reg_idx_e;

  // Result codes
  typedef enum logic [2:0] {
    VerdictValid   = 3'd0,
    VerdictFlagBad = 3'd1,
    VerdictAddrBad = 3'd2,
    VerdictSizeBad = 3'd3,
    VerdictCrcBad  = 3'd4
  } verdict_e;

  // Input request
  typedef struct packed {
    logic       begin_req;
    logic [7:0] image_byte;
  } in_req_t;

  // Result
  typedef struct packed {
    verdict_e    verdict;
    logic [31:0] computed_crc;
  } out_rsp_t;

  // Configuration seen by the datapath
  typedef struct packed {
    logic [31:0]         required_flag;
    logic [31:0]         required_start;
    logic [SizeBits-1:0] size_limit;
    logic [31:0]         record_flag;
    logic [31:0]         record_start;
    logic [SizeBits-1:0] record_size;
    logic [31:0]         record_crc;
  } cfg_t;

  // One byte through the reflected CRC, bit by bit
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: rtl/fwcrc_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwcrc_regs
// APB register file holding the requirements and the metadata record.
// ----------------------------------------------------------------------------
module fwcrc_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fwcrc_pkg::AddrBits-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output fwcrc_pkg::cfg_t               cfg_o
);
  import fwcrc_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[AddrBits-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  // Register writes; indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.required_flag  <= '0;
      cfg_q.required_start <= '0;
      cfg_q.size_limit     <= '1;
      cfg_q.record_flag    <= '0;
      cfg_q.record_start   <= '0;
      cfg_q.record_size    <= '0;
      cfg_q.record_crc     <= '0;
    end else if (wr_en) begin
      case (idx)
        RegRequiredFlag:  cfg_q.required_flag  <= pwdata;
        RegRequiredStart: cfg_q.required_start <= pwdata;
        RegSizeLimit:     cfg_q.size_limit     <= pwdata[SizeBits-1:0];
        RegRecordFlag:    cfg_q.record_flag    <= pwdata;
        RegRecordStart:   cfg_q.record_start   <= pwdata;
        RegRecordSize:    cfg_q.record_size    <= pwdata[SizeBits-1:0];
        RegRecordCrc:     cfg_q.record_crc     <= pwdata;
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      RegRequiredFlag:  prdata = cfg_q.required_flag;
      RegRequiredStart: prdata = cfg_q.required_start;
      RegSizeLimit:     prdata = 32'(cfg_q.size_limit);
      RegRecordFlag:    prdata = cfg_q.record_flag;
      RegRecordStart:   prdata = cfg_q.record_start;
      RegRecordSize:    prdata = 32'(cfg_q.record_size);
      RegRecordCrc:     prdata = cfg_q.record_crc;
      default:          prdata = '0;
    endcase
  end

endmodule

// File: rtl/fwcrc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwcrc_core
// Validation state (CRC, byte count, finished) and the per-byte result logic.
// ----------------------------------------------------------------------------
module fwcrc_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fwcrc_pkg::cfg_t      cfg_i,
  input  logic                 req_valid_i,
  input  fwcrc_pkg::in_req_t   req_i,
  output logic                 res_valid_o,
  output fwcrc_pkg::out_rsp_t  res_o
);
  import fwcrc_pkg::*;

  logic [31:0]         crc_q, crc_d;
  logic [SizeBits-1:0] cnt_q, cnt_d;
  logic                fin_q, fin_d;

  logic [31:0]         crc_upd;
  logic [SizeBits-1:0] cnt_upd;
  logic [31:0]         crc_final;
  logic                size_bad;

  // A begin request restarts from the initial CRC and a zero count
  assign crc_upd   = crc_byte(req_i.begin_req ? CrcOnes : crc_q, req_i.image_byte);
  assign cnt_upd   = (req_i.begin_req ? '0 : cnt_q) + SizeBits'(1);
  assign crc_final = crc_upd ^ CrcOnes;
  assign size_bad  = (cfg_i.record_size == '0) ||
                     (cfg_i.record_size > cfg_i.size_limit);

  // Header checks in order flag, address, size; then stream the byte
  always_comb begin
    crc_d       = crc_q;
    cnt_d       = cnt_q;
    fin_d       = fin_q;
    res_valid_o = 1'b0;
    res_o       = '{verdict: VerdictValid, computed_crc: '0};
    if (req_valid_i && (req_i.begin_req || !fin_q)) begin
      if (req_i.begin_req && (cfg_i.record_flag != cfg_i.required_flag)) begin
        crc_d = CrcOnes;  cnt_d = '0;  fin_d = 1'b1;
        res_valid_o = 1'b1;
        res_o.verdict = VerdictFlagBad;
      end else if (req_i.begin_req &&
                   (cfg_i.record_start != cfg_i.required_start)) begin
        crc_d = CrcOnes;  cnt_d = '0;  fin_d = 1'b1;
        res_valid_o = 1'b1;
        res_o.verdict = VerdictAddrBad;
      end else if (req_i.begin_req && size_bad) begin
        crc_d = CrcOnes;  cnt_d = '0;  fin_d = 1'b1;
        res_valid_o = 1'b1;
        res_o.verdict = VerdictSizeBad;
      end else begin
        crc_d = crc_upd;
        cnt_d = cnt_upd;
        fin_d = 1'b0;
        if (cnt_upd >= cfg_i.record_size) begin
          fin_d              = 1'b1;
          res_valid_o        = 1'b1;
          res_o.computed_crc = crc_final;
          res_o.verdict      = (crc_final == cfg_i.record_crc) ? VerdictValid
                                                               : VerdictCrcBad;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CrcOnes;
      cnt_q <= '0;
      fin_q <= 1'b1;
    end else begin
      crc_q <= crc_d;
      cnt_q <= cnt_d;
      fin_q <= fin_d;
    end
  end

endmodule

// File: rtl/fwcrc_outbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwcrc_outbuf
// Output register with one skid entry so the input stall is registered.
// ----------------------------------------------------------------------------
module fwcrc_outbuf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 res_valid_i,
  input  fwcrc_pkg::out_rsp_t  res_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fwcrc_pkg::out_rsp_t  out_rsp_o
);
  import fwcrc_pkg::*;

  logic     main_vld_q, main_vld_d;
  logic     skid_vld_q, skid_vld_d;
  out_rsp_t main_q, main_d;
  out_rsp_t skid_q, skid_d;
  logic     take;

  assign take        = main_vld_q && !out_stall_i;
  assign out_valid_o = main_vld_q;
  assign out_rsp_o   = main_q;
  assign full_o      = skid_vld_q;

  // New results never arrive while the skid entry is full
  always_comb begin
    main_vld_d = main_vld_q;
    skid_vld_d = skid_vld_q;
    main_d     = main_q;
    skid_d     = skid_q;
    if (skid_vld_q) begin
      if (take) begin
        main_d     = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (res_valid_i) begin
      if (!main_vld_q || take) begin
        main_d     = res_i;
        main_vld_d = 1'b1;
      end else begin
        skid_d     = res_i;
        skid_vld_d = 1'b1;
      end
    end else if (take) begin
      main_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

// File: rtl/firmware_image_crc_validator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// firmware_image_crc_validator_unit
// Checks a firmware image's record header and reflected CRC-32.
// ----------------------------------------------------------------------------
// One image byte is taken every cycle while in_stall_o is low: the full
// byte-wise CRC-32 update, the count and the compare against the record sit
// between the state registers and a result register, filled by the request
// that ends the image (or fails the header). A two-entry output buffer
// keeps the input accepting while a result waits; in_stall_o rises only
// when both entries are held. Program the registers over APB while idle,
// then send a request with begin_req set carrying the first image byte.
module firmware_image_crc_validator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  fwcrc_pkg::in_req_t            in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output fwcrc_pkg::out_rsp_t           out_rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fwcrc_pkg::AddrBits-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import fwcrc_pkg::*;

  cfg_t     cfg;
  logic     full;
  logic     res_valid;
  out_rsp_t res;

  assign in_stall_o = full;

  fwcrc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fwcrc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .req_valid_i (in_valid_i && !full),
    .req_i       (in_req_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  fwcrc_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
